>>> design/shs_pkg.sv
// Shared types, constants and helper functions of the SHA-256 stream hasher.
package shs_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int WORD_W              = 32;
    localparam int HASH_WORDS          = 8;
    localparam int BLOCK_BYTES         = 64;
    localparam int BLOCK_W             = BLOCK_BYTES * 8;
    localparam int FILL_W              = $clog2(BLOCK_BYTES);
    localparam int COUNT_W             = 61;   // byte count bits that reach the length field
    localparam int ROUNDS              = 64;
    localparam int ROUND_W             = $clog2(ROUNDS);

    localparam logic [FILL_W-1:0] LEN_START   = FILL_W'(BLOCK_BYTES - 8);
    localparam logic [FILL_W-1:0] LAST_ZERO   = FILL_W'(BLOCK_BYTES - 9);
    localparam logic [FILL_W-1:0] FILL_LAST   = FILL_W'(BLOCK_BYTES - 1);
    localparam logic [7:0]        PAD_MARK    = 8'h80;
    localparam logic [2:0]        LAST_INDEX  = 3'd7;
    localparam logic [ROUND_W-1:0] ROUND_LAST = ROUND_W'(ROUNDS - 1);

    typedef logic [HASH_WORDS-1:0][WORD_W-1:0] word_arr_t;

    localparam word_arr_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [WORD_W-1:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic {
        CMD_ABSORB,
        CMD_FINISH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic start;
        logic reinit;
    } comp_ctrl_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MARK,
        BK_ZERO,
        BK_LEN,
        BK_WAIT,
        BK_EMIT
    } back_state_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_ROUND,
        CP_ADD
    } comp_state_t;

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] bsig0(input logic [WORD_W-1:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] bsig1(input logic [WORD_W-1:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] ssig0(input logic [WORD_W-1:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] ssig1(input logic [WORD_W-1:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> design/shs_if.sv
// Handshake channels of the hasher: message requests in, digest words out.
interface shs_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface shs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    modport source (output valid, output digest_word, output word_index, output last,
                    input ready);
    modport sink   (input valid, input digest_word, input word_index, input last,
                    output ready);
endinterface

>>> design/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: front stage, command queue, back end.
//
//  channel  | dir | request payload                  | notes
//  ---------+-----+----------------------------------+---------------------------------
//  msg      | in  | op, data_byte                    | op 0 absorbs a byte, op 1 finishes
//  digest   | out | digest_word, word_index, last    | eight requests per finish
//
// Every 64th byte hands the block to the compression unit, which runs its steps
// (load, 64 rounds, chaining add) while the next block fills, so a long message
// streams at about one byte per cycle while the compression unit keeps up.
// A finish shifts in 9 to 72 padding bytes, then waits out the final compression
// and loads eight digest words into the output register, one per cycle while taken.
// Reset clears all control state and restores the initial chaining words at once.
// Either side may stall: the front register and the queue hold requests while
// the back end works, and the output register holds a word until it is taken.
module sha256_stream_hasher #(
    parameter int QueueDepth = shs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    shs_in_if.sink    msg,
    shs_out_if.source digest
);
    import shs_pkg::*;

    logic               push;
    cmd_t               push_data;
    logic               push_ready;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;
    comp_ctrl_t         comp_ctrl;
    logic [BLOCK_W-1:0] block;
    logic               comp_busy;
    word_arr_t          hash;

    // classify incoming requests
    shs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    // decouple the front from stalls in the back end
    shs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (cmd_valid),
        .pop_data   (cmd),
        .pop        (cmd_pop)
    );

    // buffer bytes, pad, sequence compressions and drive the digest
    shs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .comp_ctrl (comp_ctrl),
        .block     (block),
        .comp_busy (comp_busy),
        .hash      (hash),
        .digest    (digest)
    );

    // round engine and chaining words
    shs_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (comp_ctrl),
        .block (block),
        .busy  (comp_busy),
        .hash  (hash)
    );

endmodule

>>> design/shs_front.sv
// Front stage: take message requests and turn them into absorb/finish commands.
module shs_front (
    input  logic          clk,
    input  logic          rst_n,
    shs_in_if.sink        msg,
    output logic          push,
    output shs_pkg::cmd_t push_data,
    input  logic          push_ready
);
    import shs_pkg::*;

    logic slot_valid_reg;
    logic slot_valid_next;
    cmd_t slot_reg;
    cmd_t slot_next;
    cmd_t classified;
    logic take;

    always_comb
    begin
        classified.kind = msg.op ? CMD_FINISH : CMD_ABSORB;
        classified.data = msg.op ? 8'h00 : msg.data_byte;
    end

    assign msg.ready = !slot_valid_reg || push_ready;
    assign take      = msg.valid && msg.ready;
    assign push      = slot_valid_reg;
    assign push_data = slot_reg;

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_next       = slot_reg;
        if (take)
        begin
            slot_valid_next = 1'b1;
            slot_next       = classified;
        end
        else if (push_ready)
        begin
            slot_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

>>> design/shs_queue.sv
// Short command queue between the front stage and the back end.
module shs_queue #(
    parameter int Depth = shs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  shs_pkg::cmd_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output shs_pkg::cmd_t pop_data,
    input  logic          pop
);
    import shs_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    cmd_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CntFull);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/shs_compress.sv
// Iterative SHA-256 compression: one round per cycle, holds the chaining words.
module shs_compress (
    input  logic                          clk,
    input  logic                          rst_n,
    input  shs_pkg::comp_ctrl_t           ctrl,
    input  logic [shs_pkg::BLOCK_W-1:0]   block,
    output logic                          busy,
    output shs_pkg::word_arr_t            hash
);
    import shs_pkg::*;

    comp_state_t        state_reg;
    comp_state_t        state_next;
    word_arr_t          h_reg;
    word_arr_t          v_reg;
    logic [WORD_W-1:0]  win_reg [16];
    logic [ROUND_W-1:0] round_reg;
    logic [WORD_W-1:0]  t1;
    logic [WORD_W-1:0]  t2;
    logic [WORD_W-1:0]  ch;
    logic [WORD_W-1:0]  maj;
    logic [WORD_W-1:0]  w_new;

    // round datapath
    always_comb
    begin
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        maj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1    = v_reg[7] + bsig1(v_reg[4]) + ch + ROUND_K[round_reg] + win_reg[0];
        t2    = bsig0(v_reg[0]) + maj;
        w_new = ssig1(win_reg[14]) + win_reg[9] + ssig0(win_reg[1]) + win_reg[0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CP_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = CP_ROUND;
                end
            end
            CP_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = CP_ADD;
                end
            end
            CP_ADD:
            begin
                state_next = CP_IDLE;
            end
            default:
            begin
                state_next = CP_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != CP_IDLE);
        hash = h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CP_IDLE;
            h_reg     <= HASH_IV;
        end
        else
        begin
            state_reg <= state_next;
            if (ctrl.reinit)
            begin
                h_reg <= HASH_IV;
            end
            else if (state_reg == CP_ADD)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    // working variables, schedule window and round counter
    always_ff @(posedge clk)
    begin
        if (state_reg == CP_IDLE && ctrl.start)
        begin
            v_reg     <= h_reg;
            round_reg <= '0;
            for (int i = 0; i < 16; i++)
            begin
                win_reg[i] <= block[BLOCK_W - 1 - WORD_W * i -: WORD_W];
            end
        end
        else if (state_reg == CP_ROUND)
        begin
            v_reg[7]  <= v_reg[6];
            v_reg[6]  <= v_reg[5];
            v_reg[5]  <= v_reg[4];
            v_reg[4]  <= v_reg[3] + t1;
            v_reg[3]  <= v_reg[2];
            v_reg[2]  <= v_reg[1];
            v_reg[1]  <= v_reg[0];
            v_reg[0]  <= t1 + t2;
            round_reg <= round_reg + 1'b1;
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
    end

endmodule

>>> design/shs_back.sv
// Back end: block buffer, padding sequencer and digest output register.
module shs_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  shs_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    output shs_pkg::comp_ctrl_t           comp_ctrl,
    output logic [shs_pkg::BLOCK_W-1:0]   block,
    input  logic                          comp_busy,
    input  shs_pkg::word_arr_t            hash,
    shs_out_if.source                     digest
);
    import shs_pkg::*;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [BLOCK_W-1:0]  block_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic                full_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [2:0]          idx_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   out_word_reg;
    logic [2:0]          out_index_reg;
    logic                out_last_reg;

    logic                can_shift;
    logic                shift_en;
    logic [7:0]          shift_byte;
    logic                count_en;
    logic                load_out;
    logic                finish_done;
    logic [63:0]         len_bits;
    logic [2:0]          len_sel;

    assign can_shift = !full_reg;
    assign len_bits  = {count_reg, 3'b000};
    assign len_sel   = 3'(7 - int'(fill_reg[2:0]));
    assign block     = block_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && can_shift && cmd.kind == CMD_FINISH)
                begin
                    state_next = BK_MARK;
                end
            end
            BK_MARK:
            begin
                if (can_shift)
                begin
                    state_next = (fill_reg == LAST_ZERO) ? BK_LEN : BK_ZERO;
                end
            end
            BK_ZERO:
            begin
                if (can_shift && fill_reg == LAST_ZERO)
                begin
                    state_next = BK_LEN;
                end
            end
            BK_LEN:
            begin
                if (can_shift && fill_reg == FILL_LAST)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (!full_reg && !comp_busy)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (finish_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop          = 1'b0;
        shift_en         = 1'b0;
        shift_byte       = 8'h00;
        count_en         = 1'b0;
        load_out         = 1'b0;
        finish_done      = 1'b0;
        comp_ctrl.start  = full_reg && !comp_busy;
        comp_ctrl.reinit = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_pop = cmd_valid && can_shift;
                if (cmd_pop && cmd.kind == CMD_ABSORB)
                begin
                    shift_en   = 1'b1;
                    shift_byte = cmd.data;
                    count_en   = 1'b1;
                end
            end
            BK_MARK:
            begin
                shift_en   = can_shift;
                shift_byte = PAD_MARK;
            end
            BK_ZERO:
            begin
                shift_en = can_shift;
            end
            BK_LEN:
            begin
                shift_en   = can_shift;
                shift_byte = len_bits[8 * len_sel +: 8];
            end
            BK_WAIT:
            begin
                shift_en = 1'b0;
            end
            BK_EMIT:
            begin
                load_out         = !out_valid_reg || digest.ready;
                finish_done      = load_out && idx_reg == LAST_INDEX;
                comp_ctrl.reinit = finish_done;
            end
            default:
            begin
                shift_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            fill_reg      <= '0;
            full_reg      <= 1'b0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en)
            begin
                fill_reg <= fill_reg + 1'b1;
                if (fill_reg == FILL_LAST)
                begin
                    full_reg <= 1'b1;
                end
            end
            else if (comp_ctrl.start)
            begin
                full_reg <= 1'b0;
            end
            if (finish_done)
            begin
                count_reg <= '0;
            end
            else if (count_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == BK_WAIT)
            begin
                idx_reg <= '0;
            end
            else if (load_out)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digest.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            block_reg <= {block_reg[BLOCK_W-9:0], shift_byte};
        end
        if (load_out)
        begin
            out_word_reg  <= hash[idx_reg];
            out_index_reg <= idx_reg;
            out_last_reg  <= (idx_reg == LAST_INDEX);
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_index_reg;
    assign digest.last        = out_last_reg;

endmodule

>>> verif/shs_digest_checker.sv
`timescale 1ns / 100ps
// Digest checker: tracks the SHA-256 state of the hasher and checks every digest word.
module shs_digest_checker (
    input  logic clk,
    input  logic rst_n,
    shs_in_if    msg,
    shs_out_if   digest,
    output int   fail_count,
    output int   pending,
    output int   words_checked
);

    localparam int         BLOCK_LEN = 64;
    localparam int         LEN_POS   = 56;   // first byte of the length field
    localparam int         LAST_WORD = 7;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TABLE [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        is_last;
    } digest_entry_t;

    logic [31:0]   chain [8];
    logic [7:0]    block_buf [BLOCK_LEN];
    int            fill_level;
    logic [63:0]   msg_bytes;
    logic [63:0]   bit_len;
    digest_entry_t entry;
    digest_entry_t expected_digest [$];
    int            mismatches;
    int            checked;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // one compression of block_buf into chain
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
            v[i] = chain[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            chain[i] = chain[i] + v[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            chain[i] = IV_TABLE[i];
        fill_level = 0;
        msg_bytes  = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_message();
            expected_digest.delete();
            mismatches = 0;
            checked    = 0;
            fail_count    <= 0;
            pending       <= 0;
            words_checked <= 0;
        end
        else
        begin
            // compare first, so a word in the same cycle as a finish never matches it
            if (digest.valid && digest.ready)
            begin
                if (expected_digest.size() == 0)
                begin
                    $error("digest word %h (word_index %0d) with no digest pending",
                           digest.digest_word, digest.word_index);
                    mismatches++;
                end
                else
                begin
                    entry = expected_digest.pop_front();
                    if (digest.digest_word !== entry.word)
                    begin
                        $error("digest_word: expected %h, got %h", entry.word,
                               digest.digest_word);
                        mismatches++;
                    end
                    if (digest.word_index !== entry.idx)
                    begin
                        $error("word_index: expected %0d, got %0d", entry.idx,
                               digest.word_index);
                        mismatches++;
                    end
                    if (digest.last !== entry.is_last)
                    begin
                        $error("last: expected %0b, got %0b", entry.is_last, digest.last);
                        mismatches++;
                    end
                    checked++;
                end
            end

            if (msg.valid && msg.ready)
            begin
                if (msg.op == shs_pkg::CMD_ABSORB)
                begin
                    block_buf[fill_level] = msg.data_byte;
                    msg_bytes  = msg_bytes + 64'd1;
                    fill_level = fill_level + 1;
                    if (fill_level == BLOCK_LEN)
                    begin
                        sha_compress();
                        fill_level = 0;
                    end
                end
                else
                begin
                    // pad: marker, zeros, then bit length; spill to a second block
                    // when the marker lands inside the length field
                    block_buf[fill_level] = PAD_BYTE;
                    for (int i = fill_level + 1; i < BLOCK_LEN; i++)
                        block_buf[i] = 8'h00;
                    if (fill_level >= LEN_POS)
                    begin
                        sha_compress();
                        for (int i = 0; i < LEN_POS; i++)
                            block_buf[i] = 8'h00;
                    end
                    bit_len = msg_bytes << 3;
                    for (int i = 0; i < 8; i++)
                        block_buf[LEN_POS + i] = bit_len[63 - 8*i -: 8];
                    sha_compress();
                    for (int i = 0; i < 8; i++)
                    begin
                        entry.word    = chain[i];
                        entry.idx     = 3'(i);
                        entry.is_last = (i == LAST_WORD);
                        expected_digest.push_back(entry);
                    end
                    restart_message();
                end
            end

            fail_count    <= mismatches;
            pending       <= expected_digest.size();
            words_checked <= checked;
        end
    end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: drives message requests and digest back-pressure, gives the verdict.
module tb_top;

    localparam int CLK_PERIOD  = 10;
    localparam int TOTAL_ITEMS = 410;     // directed plus random requests in total
    localparam int CYCLE_LIMIT = 300000;  // far beyond the slowest legal run
    localparam int TAIL_CYCLES = 200;     // covers a two-block finish plus the emit

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int idle_pct  = 0;    // chance in a hundred that the sender skips a cycle
    int stall_pct = 0;    // chance in a hundred that the receiver holds off
    int items_sent    = 0;
    int bytes_sent    = 0;
    int messages_sent = 0;
    int cycle_count   = 0;
    int msg_len;

    int fail_count;
    int pending;
    int words_checked;

    shs_in_if  msg_ch ();
    shs_out_if digest_ch ();

    sha256_stream_hasher dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // The checker sees both channels, predicts every digest and counts mismatches.
    shs_digest_checker digest_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .msg           (msg_ch),
        .digest        (digest_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver back-pressure: drop ready at random according to the current phase.
    always @(posedge clk)
        digest_ch.ready <= ($urandom_range(99) >= stall_pct);

    // Watchdog: end the run if the hasher hangs or never drains its digests.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words still pending",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one request. Insert random gaps first (valid low), then hold the
    // request until the hasher takes it. Valid stays high into the next request
    // when no gap follows, so it is never lowered and raised in one step.
    task automatic send_request(input shs_pkg::cmd_kind_t kind, input logic [7:0] value);
        while ($urandom_range(99) < idle_pct)
        begin
            msg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        msg_ch.valid     <= 1'b1;
        msg_ch.op        <= kind;
        msg_ch.data_byte <= value;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        items_sent++;
        if (kind == shs_pkg::CMD_ABSORB)
            bytes_sent++;
        else
            messages_sent++;
    endtask

    initial
    begin
        msg_ch.valid     <= 1'b0;
        msg_ch.op        <= shs_pkg::CMD_ABSORB;
        msg_ch.data_byte <= 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling on either side.
        // Empty message; the byte on a finish must be ignored.
        send_request(shs_pkg::CMD_FINISH, 8'hff);
        // Classic three-byte message.
        send_request(shs_pkg::CMD_ABSORB, 8'h61);
        send_request(shs_pkg::CMD_ABSORB, 8'h62);
        send_request(shs_pkg::CMD_ABSORB, 8'h63);
        send_request(shs_pkg::CMD_FINISH, 8'h00);
        // Byte extremes and the marker value itself as data.
        send_request(shs_pkg::CMD_ABSORB, 8'h00);
        send_request(shs_pkg::CMD_ABSORB, 8'hff);
        send_request(shs_pkg::CMD_ABSORB, 8'h80);
        send_request(shs_pkg::CMD_ABSORB, 8'h7f);
        send_request(shs_pkg::CMD_FINISH, 8'h5a);
        // Back-to-back finishes, one after a single byte: the state must come back
        // to its initial value after every finish.
        send_request(shs_pkg::CMD_FINISH, 8'h00);
        send_request(shs_pkg::CMD_ABSORB, 8'hff);
        send_request(shs_pkg::CMD_FINISH, 8'hff);
        send_request(shs_pkg::CMD_FINISH, 8'h00);

        // Random part: whole messages with random bytes. Lengths lean on short
        // messages and on the block boundary (one- and two-block padding, exact
        // block fills); some run past a full block.
        while (items_sent < TOTAL_ITEMS)
        begin
            // advance through the idling phases as the request count grows
            case (items_sent * 4 / TOTAL_ITEMS)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 46;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 46;
                end
                default:
                begin
                    idle_pct  = 11;
                    stall_pct = 11;
                end
            endcase
            case ($urandom_range(4))
                0, 1:    msg_len = $urandom_range(8);
                2, 3:    msg_len = $urandom_range(66, 52);
                default: msg_len = $urandom_range(130);
            endcase
            // keep the last message inside the request budget
            if (msg_len > TOTAL_ITEMS - items_sent - 1)
                msg_len = TOTAL_ITEMS - items_sent - 1;
            for (int k = 0; k < msg_len; k++)
                send_request(shs_pkg::CMD_ABSORB, 8'($urandom_range(255)));
            send_request(shs_pkg::CMD_FINISH, 8'($urandom_range(255)));
        end
        msg_ch.valid <= 1'b0;
        idle_pct  = 0;
        stall_pct = 0;

        // Let the checker see the last request, drain every digest, then hold
        // a while longer to catch stray words.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("hashed %0d messages (%0d bytes, %0d requests) under four idling phases",
                 messages_sent, bytes_sent, items_sent);
        $display("compared %0d digest words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
